@@ sv/ish_pkg.sv @@
package ish_pkg;

	// Storage geometry.
	localparam int MAX_LEN     = 1024;
	localparam int STORE_DEPTH = MAX_LEN + 1;
	localparam int LEN_W       = $clog2(STORE_DEPTH);

	// Hash word and the digit-serial multiplier geometry.
	localparam int HASH_W      = 64;
	localparam int DIGIT_W     = 8;
	localparam int MUL_DIGITS  = HASH_W / DIGIT_W;
	localparam int DIGIT_CNT_W = $clog2(MUL_DIGITS);

	localparam logic [HASH_W-1:0] BASE_RESET = 64'd100000000003;

	// Configuration port: one 64-bit register, byte address 8*i.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 64;
	localparam logic REG_BASE = 1'b0;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_QUERY   = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       byte_value;
		logic [LEN_W-1:0] query_start;
		logic [LEN_W-1:0] query_end;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [HASH_W-1:0] hash_value;
		logic [LEN_W-1:0]  current_length;
	} result_t;

	// Write request into the prefix and power tables.
	typedef struct packed {
		logic              en;
		logic [LEN_W-1:0]  addr;
		logic [HASH_W-1:0] prefix;
		logic [HASH_W-1:0] power;
	} store_wr_t;

	// Addition modulo 2^64-1: the carry out wraps into bit zero.
	function automatic logic [HASH_W-1:0] eac_add(input logic [HASH_W-1:0] a,
		input logic [HASH_W-1:0] b);
		logic [HASH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[HASH_W-1:0] + {{(HASH_W-1){1'b0}}, s[HASH_W]};
	endfunction

	// The all-ones word is the second form of zero.
	function automatic logic [HASH_W-1:0] normalize(input logic [HASH_W-1:0] x);
		return (x == '1) ? '0 : x;
	endfunction

endpackage

@@ sv/ish_store.sv @@
module ish_store (
	input  logic                          clk,
	input  ish_pkg::store_wr_t            wr,
	input  logic [ish_pkg::LEN_W-1:0]     prefix_addr,
	input  logic [ish_pkg::LEN_W-1:0]     power_addr,
	output logic [ish_pkg::HASH_W-1:0]    prefix_data,
	output logic [ish_pkg::HASH_W-1:0]    power_data
);

	logic [ish_pkg::HASH_W-1:0] prefix_mem [0:ish_pkg::STORE_DEPTH-1];
	logic [ish_pkg::HASH_W-1:0] power_mem  [0:ish_pkg::STORE_DEPTH-1];
	logic [ish_pkg::HASH_W-1:0] prefix_rd_q;
	logic [ish_pkg::HASH_W-1:0] power_rd_q;
	logic                       prefix_zero_q;
	logic                       power_zero_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			prefix_mem[wr.addr] <= wr.prefix;
			power_mem[wr.addr]  <= wr.power;
		end
	end

	always_ff @(posedge clk) begin
		prefix_rd_q   <= prefix_mem[prefix_addr];
		power_rd_q    <= power_mem[power_addr];
		prefix_zero_q <= (prefix_addr == '0);
		power_zero_q  <= (power_addr == '0);
	end

	// Entry zero is never written; it always reads as the empty-string values.
	assign prefix_data = prefix_zero_q ? '0 : prefix_rd_q;
	assign power_data  = power_zero_q ? ish_pkg::HASH_W'(1) : power_rd_q;

endmodule

@@ sv/ish_mul.sv @@
module ish_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ish_pkg::HASH_W-1:0] a,
	input  logic [ish_pkg::HASH_W-1:0] b,
	output logic                       done,
	output logic [ish_pkg::HASH_W-1:0] result
);

	logic [ish_pkg::HASH_W-1:0]      a_q;
	logic [ish_pkg::HASH_W-1:0]      b_q;
	logic [ish_pkg::HASH_W-1:0]      acc_q;
	logic [ish_pkg::DIGIT_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [ish_pkg::DIGIT_W-1:0]                  digit;
	logic [ish_pkg::HASH_W-1:0]                   rot;
	logic [ish_pkg::HASH_W+ish_pkg::DIGIT_W-1:0]  prod;
	logic [ish_pkg::HASH_W+ish_pkg::DIGIT_W-1:0]  sum;
	logic [ish_pkg::HASH_W-1:0]                   acc_next;

	// Horner step over the digits of b, most significant first. Since
	// 2^64 is one modulo 2^64-1, scaling the accumulator by the digit
	// radix is a left rotation.
	always_comb begin
		digit    = b_q[ish_pkg::HASH_W-1 -: ish_pkg::DIGIT_W];
		rot      = {acc_q[ish_pkg::HASH_W-ish_pkg::DIGIT_W-1:0],
			acc_q[ish_pkg::HASH_W-1 -: ish_pkg::DIGIT_W]};
		prod     = {{ish_pkg::DIGIT_W{1'b0}}, a_q} *
			{{ish_pkg::HASH_W{1'b0}}, digit};
		sum      = prod + {{ish_pkg::DIGIT_W{1'b0}}, rot};
		acc_next = ish_pkg::eac_add(sum[ish_pkg::HASH_W-1:0],
			{{(ish_pkg::HASH_W-ish_pkg::DIGIT_W){1'b0}},
			sum[ish_pkg::HASH_W+ish_pkg::DIGIT_W-1:ish_pkg::HASH_W]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + ish_pkg::DIGIT_CNT_W'(1);
				if (cnt_q == ish_pkg::DIGIT_CNT_W'(ish_pkg::MUL_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << ish_pkg::DIGIT_W;
			acc_q <= acc_next;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

@@ sv/interval_string_hash_core.sv @@
// Polynomial string hash modulo 2^64-1 with interval queries.
// Items enter on the item channel (item_valid, item_stall, item) and one result
// beat per item leaves on the result channel (result_valid, result_stall,
// result). A beat moves at a rising edge where valid is high and stall is low.
// An append adds one byte and reports the new prefix hash, a query reports the
// hash of bytes [query_start, query_end), and a restart empties the string.
// The hash base is written through the APB port at byte address 0.
// The block works on one item at a time. Appends and queries pass through
// the read, load, multiply and response steps; the 64x64 product modulo
// 2^64-1 is formed one 8-bit digit per cycle. Restarts, rejected items and
// the unused action code go straight to the response step. The next item is
// accepted the cycle after the result enters the output register.
// While the result receiver stalls, the finished beat waits in the output
// register and the next item is still accepted and processed; its result
// then waits until the output register is free.
// Reset empties the string and loads the default base; no clearing pass
// runs, and table entries above the stored length are never read.
module interval_string_hash_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  ish_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output ish_pkg::result_t               result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ish_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ish_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ish_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_MUL,
		S_RESP
	} state_t;

	state_t                       state_q;
	ish_pkg::item_t               item_q;
	logic [ish_pkg::LEN_W-1:0]    len_q;
	logic [ish_pkg::LEN_W-1:0]    addr_prefix_q;
	logic [ish_pkg::LEN_W-1:0]    addr_power_q;
	logic [1:0]                   pend_status_q;
	logic [ish_pkg::HASH_W-1:0]   pend_hash_q;
	logic                         out_valid_q;
	ish_pkg::result_t             out_q;
	logic [ish_pkg::HASH_W-1:0]   base_q;

	logic                         item_fire;
	logic                         cfg_write;
	logic                         is_append;
	logic                         mul_start;
	logic [ish_pkg::HASH_W-1:0]   mul0_b;
	logic                         mul0_done;
	logic                         mul1_done;
	logic [ish_pkg::HASH_W-1:0]   mul0_res;
	logic [ish_pkg::HASH_W-1:0]   mul1_res;
	logic [ish_pkg::HASH_W-1:0]   prefix_rd;
	logic [ish_pkg::HASH_W-1:0]   power_rd;
	logic [ish_pkg::HASH_W-1:0]   new_prefix;
	logic [ish_pkg::HASH_W-1:0]   final_hash;
	logic                         out_free;
	ish_pkg::store_wr_t           wr;

	// Configuration register. The base is to be written only while no item
	// is in flight.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[ish_pkg::CFG_ADDR_W-1] == ish_pkg::REG_BASE) ? base_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ish_pkg::BASE_RESET;
		end else if (cfg_write && paddr[ish_pkg::CFG_ADDR_W-1] == ish_pkg::REG_BASE) begin
			base_q <= pwdata;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign item_fire    = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;

	assign is_append = (item_q.action == ish_pkg::ACT_APPEND);

	// Both multipliers start together. For an append, unit 0 scales the
	// previous prefix hash and unit 1 the previous power; for a query, unit 0
	// forms prefix[start] * power[end - start] and unit 1 is not used.
	assign mul_start = (state_q == S_LOAD);
	assign mul0_b    = is_append ? base_q : power_rd;

	// During a query the prefix read port holds prefix[end] by now.
	assign new_prefix = ish_pkg::eac_add(mul0_res,
		{{(ish_pkg::HASH_W-8){1'b0}}, item_q.byte_value});
	assign final_hash = is_append ? new_prefix : ish_pkg::eac_add(prefix_rd, ~mul0_res);

	always_comb begin
		wr.en     = (state_q == S_MUL) && mul0_done && is_append;
		wr.addr   = len_q + ish_pkg::LEN_W'(1);
		wr.prefix = new_prefix;
		wr.power  = mul1_res;
	end

	ish_store u_store (
		.clk         (clk),
		.wr          (wr),
		.prefix_addr (addr_prefix_q),
		.power_addr  (addr_power_q),
		.prefix_data (prefix_rd),
		.power_data  (power_rd)
	);

	ish_mul u_mul0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (prefix_rd),
		.b      (mul0_b),
		.done   (mul0_done),
		.result (mul0_res)
	);

	ish_mul u_mul1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (power_rd),
		.b      (base_q),
		.done   (mul1_done),
		.result (mul1_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			item_q        <= '0;
			len_q         <= '0;
			addr_prefix_q <= '0;
			addr_power_q  <= '0;
			pend_status_q <= ish_pkg::STAT_OK;
			pend_hash_q   <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			// In the response step the output register is either refilled or
			// still stalled, so the beat is only dropped in the other steps.
			if (out_valid_q && !result_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						item_q        <= item;
						pend_status_q <= ish_pkg::STAT_OK;
						pend_hash_q   <= '0;
						state_q       <= S_RESP;
						case (item.action)
							ish_pkg::ACT_APPEND: begin
								if (len_q >= ish_pkg::LEN_W'(ish_pkg::MAX_LEN)) begin
									pend_status_q <= ish_pkg::STAT_FULL;
								end else begin
									addr_prefix_q <= len_q;
									addr_power_q  <= len_q;
									state_q       <= S_READ;
								end
							end
							ish_pkg::ACT_QUERY: begin
								if (item.query_start > item.query_end ||
									item.query_end > len_q) begin
									pend_status_q <= ish_pkg::STAT_RANGE;
								end else begin
									addr_prefix_q <= item.query_start;
									addr_power_q  <= item.query_end - item.query_start;
									state_q       <= S_READ;
								end
							end
							ish_pkg::ACT_RESTART: begin
								len_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					// The second prefix read of a query follows the first.
					if (item_q.action == ish_pkg::ACT_QUERY) begin
						addr_prefix_q <= item_q.query_end;
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul0_done) begin
						pend_status_q <= ish_pkg::STAT_OK;
						pend_hash_q   <= ish_pkg::normalize(final_hash);
						if (is_append) begin
							len_q <= len_q + ish_pkg::LEN_W'(1);
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_q.status         <= pend_status_q;
						out_q.hash_value     <= pend_hash_q;
						out_q.current_length <= len_q;
						out_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= ish_pkg::LEN_W'(ish_pkg::MAX_LEN))
		else $error("stored length beyond capacity");

	a_mul_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mul0_done |-> (state_q == S_MUL && mul1_done))
		else $error("multiplier finished outside the multiply step");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |=> item_stall)
		else $error("second item taken while one is in flight");
`endif

endmodule

@@ bench/interval_string_hash_core_test.sv @@
`timescale 1ns / 1ps

module interval_string_hash_core_test;
	import ish_pkg::*;

	// The unused action code has no member in the package enum.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Row kinds of the directed table: a typed-in result, or one from the hash model.
	localparam bit TYPED   = 1'b1;
	localparam bit MODELED = 1'b0;

	// Extra cycles that drain() waits after the last expected result.
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 46;
	localparam int EDGE_APPENDS = 40;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CFG_ADDR_W-1:0] BASE_ADDR = CFG_ADDR_W'(8 * int'(REG_BASE));

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	interval_string_hash_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// Hash model state: its own copy of both tables, the length and the base.
	logic [HASH_W-1:0] prefix_tbl [0:STORE_DEPTH-1];
	logic [HASH_W-1:0] power_tbl  [0:STORE_DEPTH-1];
	int                model_len;
	logic [HASH_W-1:0] model_base;

	result_t pending_results [$];
	row_t    plan [$];
	int      mismatch_cnt = 0;
	int      cycle_cnt = 0;
	bit      quiet = 1'b0;
	int      stall_hold = 0;

	// Addition modulo 2^64-1: the carry out of bit 63 comes back in at bit 0.
	function automatic logic [HASH_W-1:0] fold_add(input logic [HASH_W-1:0] a,
		input logic [HASH_W-1:0] b);
		logic [HASH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[HASH_W-1:0] + HASH_W'(s[HASH_W]);
	endfunction

	// Multiplication modulo 2^64-1: the full product with its high half folded onto the low.
	function automatic logic [HASH_W-1:0] fold_mul(input logic [HASH_W-1:0] a,
		input logic [HASH_W-1:0] b);
		logic [2*HASH_W-1:0] p;
		p = {{HASH_W{1'b0}}, a} * {{HASH_W{1'b0}}, b};
		return fold_add(p[HASH_W-1:0], p[2*HASH_W-1:HASH_W]);
	endfunction

	// All ones is the other spelling of zero and is always reported as zero.
	function automatic logic [HASH_W-1:0] canon(input logic [HASH_W-1:0] x);
		return (x == '1) ? '0 : x;
	endfunction

	// Advances the model by one item and returns the result it must produce.
	function automatic result_t hash_step(input item_t it);
		result_t           r;
		logic [HASH_W-1:0] sub;
		int                s;
		int                e;
		r = '0;
		if (it.action == ACT_APPEND) begin
			if (model_len >= MAX_LEN) begin
				r.status = STAT_FULL;
			end else begin
				prefix_tbl[model_len + 1] = fold_add(fold_mul(prefix_tbl[model_len], model_base),
					HASH_W'(it.byte_value));
				power_tbl[model_len + 1] = fold_mul(power_tbl[model_len], model_base);
				model_len++;
				r.hash_value = canon(prefix_tbl[model_len]);
			end
		end else if (it.action == ACT_QUERY) begin
			s = it.query_start;
			e = it.query_end;
			if (s > e || e > model_len) begin
				r.status = STAT_RANGE;
			end else begin
				sub = fold_mul(prefix_tbl[s], power_tbl[e - s]);
				r.hash_value = canon(fold_add(prefix_tbl[e], ~sub));
			end
		end else if (it.action == ACT_RESTART) begin
			model_len = 0;
		end
		// The unused action code leaves everything as it is.
		r.current_length = LEN_W'(model_len);
		return r;
	endfunction

	function automatic item_t mk_item(input logic [1:0] act, input logic [7:0] b,
		input int qs, input int qe);
		item_t it;
		it.action      = act;
		it.byte_value  = b;
		it.query_start = LEN_W'(qs);
		it.query_end   = LEN_W'(qe);
		return it;
	endfunction

	function automatic row_t row(input logic [1:0] act, input logic [7:0] b, input int qs,
		input int qe, input bit typed, input logic [1:0] st, input logic [HASH_W-1:0] h,
		input int len);
		row_t rw;
		rw.it                  = mk_item(act, b, qs, qe);
		rw.typed               = typed;
		rw.want.status         = st;
		rw.want.hash_value     = h;
		rw.want.current_length = LEN_W'(len);
		return rw;
	endfunction

	// Appends one row to the end of the directed table.
	task automatic add_row(input row_t rw);
		plan = {plan, rw};
	endtask

	// Random items are mostly appends and well-formed queries over the current string,
	// with a share of broken intervals, restarts and the unused code mixed in.
	function automatic item_t random_item();
		item_t it;
		int    pick;
		int    e;
		pick = $urandom_range(0, 99);
		it   = mk_item(ACT_APPEND, 8'($urandom), $urandom_range(0, 2047),
			$urandom_range(0, 2047));
		if (pick < 48) begin
			it.action = ACT_APPEND;
		end else if (pick < 78) begin
			e = $urandom_range(0, model_len);
			it.action      = ACT_QUERY;
			it.query_end   = LEN_W'(e);
			it.query_start = LEN_W'($urandom_range(0, e));
		end else if (pick < 87) begin
			// Arbitrary 11-bit bounds: nearly always out of range.
			it.action = ACT_QUERY;
		end else if (pick < 92) begin
			it.action = ACT_RESTART;
		end else if (pick < 95) begin
			it.action = ACT_UNUSED;
		end else begin
			it.action     = ACT_APPEND;
			it.byte_value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return it;
	endfunction

	// Presents one beat, possibly after a random gap, and waits until it is taken.
	// The expectation is queued at the edge where the beat moves.
	task automatic send_item(input item_t it, input bit typed, input result_t want);
		result_t modeled;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		modeled = hash_step(it);
		pending_results = {pending_results, (typed ? want : modeled)};
	endtask

	task automatic send_modeled(input item_t it);
		send_item(it, MODELED, '0);
	endtask

	// Lets every outstanding result come back, then a few more cycles for safety.
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write with a setup and an access phase; the register takes the value at the access edge.
	task automatic write_base(input logic [HASH_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BASE_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model_base = value;
	endtask

	task automatic random_phase();
		repeat (PHASE_ITEMS) send_modeled(random_item());
		drain();
	endtask

	// The receiver stalls in random bursts, separated by free-running stretches.
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_hold != 0) begin
			stall_hold--;
		end else if ($urandom_range(0, 2) == 0) begin
			result_stall <= 1'b1;
			stall_hold = $urandom_range(0, 9);
		end else begin
			result_stall <= 1'b0;
			stall_hold = $urandom_range(0, 20);
		end
	end

	// Every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("unexpected result beat: status %0d hash %h len %0d",
						result.status, result.hash_value, result.current_length);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status || result.hash_value !== want.hash_value
					|| result.current_length !== want.current_length) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("mismatch: want status %0d hash %h len %0d, got status %0d hash %h len %0d",
							want.status, want.hash_value, want.current_length,
							result.status, result.hash_value, result.current_length);
				end
			end
		end
	end

	// Watchdog: far above the slowest correct run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			prefix_tbl[i] = '0;
			power_tbl[i]  = '0;
		end
		prefix_tbl[0] = '0;
		power_tbl[0]  = HASH_W'(1);
		model_len     = 0;
		model_base    = BASE_RESET;

		// Directed table. The typed rows are the ones whose result follows from the reset
		// state or from the error rules alone; the rest come from the hash model.
		add_row(row(ACT_QUERY,   8'h00,    0,    0, TYPED,   STAT_OK,    '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    0,    1, TYPED,   STAT_RANGE, '0, 0));
		add_row(row(ACT_QUERY,   8'h00, 2047,    0, TYPED,   STAT_RANGE, '0, 0));
		// Zero times anything plus a zero byte is zero.
		add_row(row(ACT_APPEND,  8'h00, 2047, 2047, TYPED,   STAT_OK,    '0, 1));
		add_row(row(ACT_APPEND,  8'hFF,    0,    0, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_APPEND,  8'h80,    0,    0, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_APPEND,  8'h01, 1365,  682, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    0,    4, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    1,    3, MODELED, STAT_OK,    '0, 0));
		// An empty interval hashes to zero.
		add_row(row(ACT_QUERY,   8'h00,    4,    4, TYPED,   STAT_OK,    '0, 4));
		add_row(row(ACT_QUERY,   8'h00,    3,    2, TYPED,   STAT_RANGE, '0, 4));
		add_row(row(ACT_QUERY,   8'h00,    0,    5, TYPED,   STAT_RANGE, '0, 4));
		add_row(row(ACT_QUERY,   8'h00, 2047, 2047, TYPED,   STAT_RANGE, '0, 4));
		add_row(row(ACT_QUERY,   8'hFF,    0, 2047, TYPED,   STAT_RANGE, '0, 4));
		add_row(row(ACT_UNUSED,  8'hFF, 2047, 2047, TYPED,   STAT_OK,    '0, 4));
		add_row(row(ACT_QUERY,   8'hFF,    2,    4, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_RESTART, 8'hFF, 2047, 2047, TYPED,   STAT_OK,    '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    0,    1, TYPED,   STAT_RANGE, '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    0,    0, TYPED,   STAT_OK,    '0, 0));
		// The tables still hold old entries above the length; appends overwrite them.
		add_row(row(ACT_APPEND,  8'hFF,    0,    0, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    0,    1, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_APPEND,  8'h5A,    0,    0, MODELED, STAT_OK,    '0, 0));
		add_row(row(ACT_QUERY,   8'h00,    1,    2, MODELED, STAT_OK,    '0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) send_item(plan[i].it, plan[i].typed, plan[i].want);
		random_phase();

		// Grow a longer string from empty, then query around its ends.
		send_modeled(mk_item(ACT_RESTART, 8'h00, 0, 0));
		repeat (EDGE_APPENDS) send_modeled(mk_item(ACT_APPEND, 8'($urandom), 0, 0));
		send_modeled(mk_item(ACT_QUERY, 8'h00, 0, EDGE_APPENDS));
		send_modeled(mk_item(ACT_QUERY, 8'h00, EDGE_APPENDS, EDGE_APPENDS));
		send_modeled(mk_item(ACT_QUERY, 8'h00, EDGE_APPENDS - 1, EDGE_APPENDS));
		send_modeled(mk_item(ACT_QUERY, 8'h00, 0, EDGE_APPENDS + 1));
		send_modeled(mk_item(ACT_QUERY, 8'h00, 1, EDGE_APPENDS - 1));
		send_modeled(mk_item(ACT_RESTART, 8'h00, 0, 0));
		drain();

		// Base extremes: zero, all ones (zero again modulo 2^64-1), one, the top bit alone, then a random base.
		// No restart is forced between bases, so old entries can mix with new ones.
		write_base('0);
		random_phase();
		write_base('1);
		random_phase();
		write_base(HASH_W'(1));
		random_phase();
		write_base({1'b1, {(HASH_W-1){1'b0}}});
		random_phase();
		write_base({$urandom, $urandom});
		random_phase();

		// The last stretch runs with neither side idling.
		quiet = 1'b1;
		write_base({$urandom, $urandom});
		random_phase();

		if (mismatch_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/ish_pkg.sv
sv/ish_store.sv
sv/ish_mul.sv
sv/interval_string_hash_core.sv
bench/interval_string_hash_core_test.sv
